FILE: hw/rtl/bct_pkg.sv
// Shared types and constants for the blob centroid tracker.
package bct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIXEL_BITS     = 8;
  localparam int THRESH_BITS    = 32;
  localparam int POS_BITS       = 13;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 32'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_LOAD,
    S_DIV,
    S_DONE
  } bct_state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic finish;
  } bct_cmd_t;

  typedef struct packed {
    logic last_step;
  } bct_status_t;

endpackage

FILE: hw/rtl/bct_ctrl.sv
// Frame sequencing controller for the blob centroid tracker.
module bct_ctrl
  import bct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        end_of_frame,
  input  bct_status_t status,
  output bct_cmd_t    cmd,
  output logic        busy
);

  bct_state_t state;
  bct_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && end_of_frame) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.last_step) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.take = start;
      end
      S_DRAIN: begin
      end
      S_LOAD: begin
        cmd.load = 1'b1;
      end
      S_DIV: begin
        cmd.step = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/bct_datapath.sv
// Moment accumulators, shared two-lane divider and position registers.
module bct_datapath
  import bct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bct_cmd_t                      cmd,
  output bct_status_t                   status,
  input  logic [PIXEL_BITS-1:0]         pixel_value,
  input  logic [COORD_BITS-1:0]         column,
  input  logic [COORD_BITS-1:0]         row,
  input  logic                          cfg_valid,
  input  logic [THRESH_BITS-1:0]        cfg_data,
  output logic                          done,
  output logic                          found,
  output logic signed [POS_BITS-1:0]    centre_x,
  output logic signed [POS_BITS-1:0]    centre_y,
  output logic signed [POS_BITS-1:0]    previous_x,
  output logic signed [POS_BITS-1:0]    previous_y,
  output logic                          draw_segment
);

  localparam int SUM_I = PIXEL_BITS + 2 * COORD_BITS;
  localparam int SUM_W = PIXEL_BITS - 1 + 3 * COORD_BITS;
  localparam int PROD_W = PIXEL_BITS + COORD_BITS;
  localparam int CMP_W = (SUM_I > THRESH_BITS) ? SUM_I : THRESH_BITS;
  localparam int POS_W = (COORD_BITS + 1 > POS_BITS) ? COORD_BITS + 1 : POS_BITS;
  localparam int CNT_W = $clog2(SUM_W);

  logic [THRESH_BITS-1:0] area_threshold;

  logic                  pend;
  logic [PIXEL_BITS-1:0] pend_v;
  logic [PROD_W-1:0]     pend_px;
  logic [PROD_W-1:0]     pend_py;

  logic [SUM_I-1:0] sum_i;
  logic [SUM_W-1:0] sum_wx;
  logic [SUM_W-1:0] sum_wy;
  logic [SUM_I:0]   add_i;
  logic [SUM_W:0]   add_wx;
  logic [SUM_W:0]   add_wy;

  logic             found_q;
  logic [SUM_I-1:0] divisor;
  logic [SUM_W-1:0] dvd_x;
  logic [SUM_W-1:0] dvd_y;
  logic [SUM_I-1:0] rem_x;
  logic [SUM_I-1:0] rem_y;
  logic [SUM_I:0]   trial_x;
  logic [SUM_I:0]   trial_y;
  logic [SUM_I:0]   diff_x;
  logic [SUM_I:0]   diff_y;
  logic [CNT_W-1:0] count;

  logic signed [POS_W-1:0] held_x;
  logic signed [POS_W-1:0] held_y;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_threshold <= THRESH_RESET;
    end else if (cfg_valid) begin
      area_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_v  <= pixel_value;
      pend_px <= PROD_W'(pixel_value) * PROD_W'(column);
      pend_py <= PROD_W'(pixel_value) * PROD_W'(row);
    end
  end

  assign add_i  = {1'b0, sum_i} + (SUM_I + 1)'(pend_v);
  assign add_wx = {1'b0, sum_wx} + (SUM_W + 1)'(pend_px);
  assign add_wy = {1'b0, sum_wy} + (SUM_W + 1)'(pend_py);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sum_i  <= '0;
      sum_wx <= '0;
      sum_wy <= '0;
    end else if (pend) begin
      sum_i  <= add_i[SUM_I] ? '1 : add_i[SUM_I-1:0];
      sum_wx <= add_wx[SUM_W] ? '1 : add_wx[SUM_W-1:0];
      sum_wy <= add_wy[SUM_W] ? '1 : add_wy[SUM_W-1:0];
    end
  end

  assign trial_x = {rem_x, dvd_x[SUM_W-1]};
  assign trial_y = {rem_y, dvd_y[SUM_W-1]};
  assign diff_x  = trial_x - {1'b0, divisor};
  assign diff_y  = trial_y - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_q <= CMP_W'(sum_i) > CMP_W'(area_threshold);
      divisor <= sum_i;
      dvd_x   <= sum_wx;
      dvd_y   <= sum_wy;
      rem_x   <= '0;
      rem_y   <= '0;
      count   <= '0;
    end else if (cmd.step) begin
      count <= count + 1'b1;
      if (trial_x >= {1'b0, divisor}) begin
        rem_x <= diff_x[SUM_I-1:0];
        dvd_x <= {dvd_x[SUM_W-2:0], 1'b1};
      end else begin
        rem_x <= trial_x[SUM_I-1:0];
        dvd_x <= {dvd_x[SUM_W-2:0], 1'b0};
      end
      if (trial_y >= {1'b0, divisor}) begin
        rem_y <= diff_y[SUM_I-1:0];
        dvd_y <= {dvd_y[SUM_W-2:0], 1'b1};
      end else begin
        rem_y <= trial_y[SUM_I-1:0];
        dvd_y <= {dvd_y[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign status.last_step = (count == CNT_W'(SUM_W - 1));

  always_comb begin
    if (!found_q) begin
      new_x = '1;
      new_y = '1;
    end else begin
      if (dvd_x[SUM_W-1:COORD_BITS] != '0) begin
        new_x = {{(POS_W - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
      end else begin
        new_x = {{(POS_W - COORD_BITS){1'b0}}, dvd_x[COORD_BITS-1:0]};
      end
      if (dvd_y[SUM_W-1:COORD_BITS] != '0) begin
        new_y = {{(POS_W - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
      end else begin
        new_y = {{(POS_W - COORD_BITS){1'b0}}, dvd_y[COORD_BITS-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '1;
      held_y <= '1;
      done   <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        held_x <= new_x;
        held_y <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found        <= found_q;
      centre_x     <= new_x[POS_BITS-1:0];
      centre_y     <= new_y[POS_BITS-1:0];
      previous_x   <= held_x[POS_BITS-1:0];
      previous_y   <= held_y[POS_BITS-1:0];
      draw_segment <= found_q && (held_x > 0) && (held_y > 0) && (new_x > 0) && (new_y > 0);
    end
  end

endmodule

FILE: hw/rtl/blob_centroid_tracker_top.sv
// Top level of the blob centroid tracker.
//
//   Channel   Handshake              Beat
//   pixel     start, busy            pixel_value, column, row, end_of_frame
//   config    cfg_valid, cfg_ready   cfg_data (area threshold)
//   result    done strobe            found, centre_x/y, previous_x/y, draw_segment
//
// Pixels inside a frame are taken one per clock with busy low.
// After the end-of-frame pixel, busy stays high in the drain, load, divide
// and done states, the divide state running the bit-serial divider that forms
// both centroid coordinates; done is high in the first cycle after busy falls.
// Reset is synchronous; it clears the sums, sets the held position to -1,-1
// and the threshold to 1000. The receiver cannot stall; a result is shown once.
module blob_centroid_tracker_top
  import bct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [PIXEL_BITS-1:0]         pixel_value,
  input  logic [COORD_BITS-1:0]         column,
  input  logic [COORD_BITS-1:0]         row,
  input  logic                          end_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [THRESH_BITS-1:0]        cfg_data,
  output logic                          done,
  output logic                          found,
  output logic signed [POS_BITS-1:0]    centre_x,
  output logic signed [POS_BITS-1:0]    centre_y,
  output logic signed [POS_BITS-1:0]    previous_x,
  output logic signed [POS_BITS-1:0]    previous_y,
  output logic                          draw_segment
);

  bct_cmd_t    cmd;
  bct_status_t status;

  assign cfg_ready = 1'b1;

  bct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .end_of_frame (end_of_frame),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  bct_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pixel_value  (pixel_value),
    .column       (column),
    .row          (row),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .done         (done),
    .found        (found),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .previous_x   (previous_x),
    .previous_y   (previous_y),
    .draw_segment (draw_segment)
  );

endmodule

FILE: tb/bct_centroid_checker.sv
// Checker for the blob centroid tracker: predicts each frame result and compares it.
module bct_centroid_checker
  import bct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [PIXEL_BITS-1:0]      pixel_value,
  input  logic [COORD_BITS-1:0]      column,
  input  logic [COORD_BITS-1:0]      row,
  input  logic                       end_of_frame,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [THRESH_BITS-1:0]     cfg_data,
  input  logic                       done,
  input  logic                       found,
  input  logic signed [POS_BITS-1:0] centre_x,
  input  logic signed [POS_BITS-1:0] centre_y,
  input  logic signed [POS_BITS-1:0] previous_x,
  input  logic signed [POS_BITS-1:0] previous_y,
  input  logic                       draw_segment,
  output int                         mismatch_count,
  output int                         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AREA_BITS   = PIXEL_BITS + 2 * COORD_BITS;
  localparam int MOMENT_BITS = PIXEL_BITS - 1 + 3 * COORD_BITS;
  localparam logic [63:0] AREA_TOP   = (64'd1 << AREA_BITS) - 64'd1;
  localparam logic [63:0] MOMENT_TOP = (64'd1 << MOMENT_BITS) - 64'd1;
  localparam logic [63:0] COORD_TOP  = (64'd1 << COORD_BITS) - 64'd1;

  typedef struct packed {
    logic                       found;
    logic signed [POS_BITS-1:0] centre_x;
    logic signed [POS_BITS-1:0] centre_y;
    logic signed [POS_BITS-1:0] previous_x;
    logic signed [POS_BITS-1:0] previous_y;
    logic                       draw_segment;
  } frame_result_t;

  logic [THRESH_BITS-1:0]     area_threshold;
  logic [63:0]                area_sum;
  logic [63:0]                moment_x;
  logic [63:0]                moment_y;
  logic signed [POS_BITS-1:0] track_x;
  logic signed [POS_BITS-1:0] track_y;
  frame_result_t              frame_results_q[$];

  function automatic logic [63:0] add_saturating(logic [63:0] acc, logic [63:0] add,
                                                 logic [63:0] top);
    if (add > top || acc > top - add) return top;
    return acc + add;
  endfunction

  function automatic logic signed [POS_BITS-1:0] centroid_coord(logic [63:0] moment,
                                                                logic [63:0] area);
    logic [63:0] quotient;
    quotient = moment / area;
    if (quotient > COORD_TOP) quotient = COORD_TOP;
    return quotient[POS_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    logic signed [POS_BITS-1:0] last_x;
    logic signed [POS_BITS-1:0] last_y;
    if (rst) begin
      area_threshold = THRESH_RESET;
      area_sum = '0;
      moment_x = '0;
      moment_y = '0;
      track_x = -1;
      track_y = -1;
      frame_results_q.delete();
      mismatch_count = 0;
      pending_results = 0;
    end else begin
      if (done) begin
        seen = '{found, centre_x, centre_y, previous_x, previous_y, draw_segment};
        if (frame_results_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result with none expected: found=%0d centre=%0d,%0d previous=%0d,%0d draw=%0d",
                     $time, seen.found, $signed(seen.centre_x), $signed(seen.centre_y),
                     $signed(seen.previous_x), $signed(seen.previous_y), seen.draw_segment);
          end
          mismatch_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (seen !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch: expected found=%0d centre=%0d,%0d previous=%0d,%0d draw=%0d",
                       $time, want.found, $signed(want.centre_x), $signed(want.centre_y),
                       $signed(want.previous_x), $signed(want.previous_y), want.draw_segment);
              $display("%0t:                  got found=%0d centre=%0d,%0d previous=%0d,%0d draw=%0d",
                       $time, seen.found, $signed(seen.centre_x), $signed(seen.centre_y),
                       $signed(seen.previous_x), $signed(seen.previous_y), seen.draw_segment);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        area_threshold = cfg_data;
      end
      if (start && !busy) begin
        area_sum = add_saturating(area_sum, 64'(pixel_value), AREA_TOP);
        moment_x = add_saturating(moment_x, 64'(pixel_value) * 64'(column), MOMENT_TOP);
        moment_y = add_saturating(moment_y, 64'(pixel_value) * 64'(row), MOMENT_TOP);
        if (end_of_frame) begin
          last_x = track_x;
          last_y = track_y;
          want.found = area_sum > 64'(area_threshold);
          if (want.found) begin
            track_x = centroid_coord(moment_x, area_sum);
            track_y = centroid_coord(moment_y, area_sum);
            want.draw_segment = last_x > 0 && last_y > 0 && track_x > 0 && track_y > 0;
          end else begin
            track_x = -1;
            track_y = -1;
            want.draw_segment = 1'b0;
          end
          want.centre_x = track_x;
          want.centre_y = track_y;
          want.previous_x = last_x;
          want.previous_y = last_y;
          frame_results_q.push_back(want);
          area_sum = '0;
          moment_x = '0;
          moment_y = '0;
        end
      end
      pending_results = frame_results_q.size();
    end
  end

endmodule

FILE: tb/tb_blob_centroid_tracker_top.sv
// Testbench top for the blob centroid tracker: clock, reset, pixel and threshold stimulus.
module tb_blob_centroid_tracker_top;
  import bct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int RANDOM_PIXELS = 900;
  localparam int SETTLE_CYCLES = 3 + 7 + 3 * COORD_BITS + 8;
  localparam int QUIET_LIMIT   = 4000;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [PIXEL_BITS-1:0]      pixel_value;
  logic [COORD_BITS-1:0]      column;
  logic [COORD_BITS-1:0]      row;
  logic                       end_of_frame;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [THRESH_BITS-1:0]     cfg_data;
  logic                       done;
  logic                       found;
  logic signed [POS_BITS-1:0] centre_x;
  logic signed [POS_BITS-1:0] centre_y;
  logic signed [POS_BITS-1:0] previous_x;
  logic signed [POS_BITS-1:0] previous_y;
  logic                       draw_segment;
  int                         mismatch_count;
  int                         pending_results;
  int                         pixels_sent;
  logic                       steady;

  always #5 clk = ~clk;

  blob_centroid_tracker_top #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_value(pixel_value), .column(column), .row(row), .end_of_frame(end_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .found(found), .centre_x(centre_x), .centre_y(centre_y),
    .previous_x(previous_x), .previous_y(previous_y), .draw_segment(draw_segment)
  );

  bct_centroid_checker #(
    .COORD_BITS(COORD_BITS)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_value(pixel_value), .column(column), .row(row), .end_of_frame(end_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .found(found), .centre_x(centre_x), .centre_y(centre_y),
    .previous_x(previous_x), .previous_y(previous_y), .draw_segment(draw_segment),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic last);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(0, 99) < 34) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    pixel_value <= value;
    column <= x;
    row <= y;
    end_of_frame <= last;
    do @(posedge clk); while (busy);
    pixels_sent++;
  endtask

  task automatic stop_pixels();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
    stop_pixels();
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while ($urandom_range(0, 99) < 34) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [THRESH_BITS-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return THRESH_RESET;
      2: return 32'hFF00_0000;
      3: return 32'(255 * $urandom_range(1, 12));
      4: return 32'(255 * $urandom_range(1, 12) - 1);
      5: return 32'($urandom_range(0, 3000));
      6: return 32'($urandom_range(0, 32'hFF00_0000));
      default: return 32'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input bit noisy);
    int len;
    int spread;
    int cx;
    int cy;
    int px;
    int py;
    int roll;
    logic [PIXEL_BITS-1:0] value;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    spread = $urandom_range(0, 400);
    cx = $urandom_range(0, COORD_MAX);
    cy = $urandom_range(0, COORD_MAX);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        value = $urandom_range(0, 255);
        px = $urandom_range(0, COORD_MAX);
        py = $urandom_range(0, COORD_MAX);
      end else begin
        roll = $urandom_range(0, 9);
        value = (roll < 7) ? 8'd255 : (roll < 9) ? 8'd0 : 8'($urandom_range(1, 254));
        px = cx + int'($urandom_range(0, 2 * spread)) - spread;
        py = cy + int'($urandom_range(0, 2 * spread)) - spread;
        px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
        py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
      end
      send_pixel(value, px[COORD_BITS-1:0], py[COORD_BITS-1:0], i == len - 1);
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) quiet = 0;
      else quiet++;
    end
    $display("FAIL blob_centroid_tracker_top");
    $finish;
  end

  initial begin : stimulus
    int random_base;
    int done_random;
    rst = 1'b1;
    start = 1'b0;
    pixel_value = '0;
    column = '0;
    row = '0;
    end_of_frame = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pixels_sent = 0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A blob just above the reset threshold, then an empty frame.
    send_pixel(8'd255, 12'd100, 12'd200, 1'b0);
    send_pixel(8'd255, 12'd102, 12'd202, 1'b0);
    send_pixel(8'd255, 12'd104, 12'd204, 1'b0);
    send_pixel(8'd255, 12'd106, 12'd206, 1'b1);
    send_pixel(8'd0, 12'd4095, 12'd4095, 1'b1);
    // Area equal to the threshold is not found; one more pixel is.
    write_threshold(32'd1020);
    send_pixel(8'd255, 12'd10, 12'd20, 1'b0);
    send_pixel(8'd255, 12'd11, 12'd21, 1'b0);
    send_pixel(8'd255, 12'd12, 12'd22, 1'b0);
    send_pixel(8'd255, 12'd13, 12'd23, 1'b1);
    send_pixel(8'd255, 12'd4095, 12'd0, 1'b0);
    send_pixel(8'd255, 12'd0, 12'd4095, 1'b0);
    send_pixel(8'd255, 12'd4095, 12'd4095, 1'b0);
    send_pixel(8'd255, 12'd0, 12'd0, 1'b0);
    send_pixel(8'd255, 12'd2048, 12'd2048, 1'b1);
    // Zero threshold: single-pixel frames, a zero coordinate blocks the segment.
    write_threshold('0);
    send_pixel(8'd1, 12'd4095, 12'd4095, 1'b1);
    send_pixel(8'd255, 12'd0, 12'd17, 1'b1);
    send_pixel(8'd0, 12'd300, 12'd300, 1'b1);
    send_pixel(8'd128, 12'd1, 12'd1, 1'b1);
    send_pixel(8'd200, 12'd4095, 12'd0, 1'b1);
    write_threshold(32'hFF00_0000);
    send_pixel(8'd255, 12'd2730, 12'd1365, 1'b0);
    send_pixel(8'd255, 12'd1365, 12'd2730, 1'b1);

    write_threshold(THRESH_RESET);
    random_base = pixels_sent;
    done_random = 0;
    while (done_random < RANDOM_PIXELS) begin
      steady = (done_random >= 300 && done_random < 500);
      if ($urandom_range(0, 7) == 0) write_threshold(pick_threshold());
      send_frame($urandom_range(0, 9) == 0);
      done_random = pixels_sent - random_base;
    end
    steady = 1'b0;

    stop_pixels();
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS blob_centroid_tracker_top");
    end else begin
      $display("FAIL blob_centroid_tracker_top");
    end
    $finish;
  end

endmodule
